// ----- hdl/pplsr_pkg.sv -----
// Shared types, widths and helpers of the per-point linear shape regressor.
// No dependencies; every other file of the block but pplsr_ram imports this package.
package pplsr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MAX_DIMS   = 128;

  localparam int TYPE_W    = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 7;
  localparam int VAL_W     = 16;
  localparam int SHAPE_W   = 32;
  localparam int NP_W      = 7;
  localparam int ND_W      = 8;
  localparam int CFG_W     = (NP_W > ND_W) ? NP_W : ND_W;
  localparam int CFG_IDX_W = 1;

  localparam int FRAC_BITS  = 12;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

  localparam int PT_W       = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int GAIN_DEPTH = MAX_POINTS * MAX_DIMS;
  localparam int GAIN_AW    = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
  localparam int PROJ_DEPTH = MAX_POINTS * MAX_POINTS;
  localparam int PROJ_AW    = (PROJ_DEPTH > 1) ? $clog2(PROJ_DEPTH) : 1;

  localparam int PROD_W = VAL_W + SHAPE_W;
  localparam int ACC_W  = PROD_W + PT_W + 1;
  localparam int SUM_W  = ACC_W + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int NP_RESET = (64 > MAX_POINTS) ? MAX_POINTS : 64;
  localparam int ND_RESET = (128 > MAX_DIMS) ? MAX_DIMS : 128;

  typedef enum logic [TYPE_W-1:0] {
    REQ_GAIN = 2'd0,
    REQ_PROJ = 2'd1,
    REQ_BIAS = 2'd2,
    REQ_FEAT = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_POINTS = 1'b0,
    CFG_DIMS       = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_GAIN,
    OP_PROJ,
    OP_BIAS,
    OP_FEAT,
    OP_RUN
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEAT_MUL,
    ST_FEAT_ACC,
    ST_ROW,
    ST_DOT,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [NP_W-1:0] num_points;
    logic [ND_W-1:0] dims_per_point;
  } cfg_t;

  typedef struct packed {
    op_e                     op;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } cmd_t;

  function automatic logic signed [SHAPE_W-1:0] sat_shape(input logic signed [SUM_W-1:0] x);
    logic [SUM_W-SHAPE_W:0] hi;
    hi = x[SUM_W-1:SHAPE_W-1];
    if (&hi || ~|hi) begin
      return x[SHAPE_W-1:0];
    end else if (x[SUM_W-1]) begin
      return {1'b1, {(SHAPE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SHAPE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- hdl/pplsr_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pplsr_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pplsr_front.sv -----
// Front end: accepts input transactions, range-checks and classifies them into commands.
// Depends on pplsr_pkg.
module pplsr_front (
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [pplsr_pkg::TYPE_W-1:0]     req_type_i,
  input  logic [pplsr_pkg::ROW_W-1:0]      row_index_i,
  input  logic [pplsr_pkg::COL_W-1:0]      col_index_i,
  input  logic signed [pplsr_pkg::VAL_W-1:0] value_i,
  input  logic                             last_feature_i,
  input  pplsr_pkg::cfg_t                  cfg_i,
  input  logic                             q_full_i,
  output logic                             push_o,
  output pplsr_pkg::cmd_t                  cmd_o
);
  import pplsr_pkg::*;

  logic keep;
  logic row_tab_ok;
  logic feat_ok;
  op_e  op;

  assign row_tab_ok = 32'(row_index_i) < 32'(MAX_POINTS);
  assign feat_ok    = (32'(row_index_i) < 32'(cfg_i.num_points)) &&
                      (32'(col_index_i) < 32'(cfg_i.dims_per_point));

  always_comb begin
    op   = OP_RUN;
    keep = 1'b0;
    case (req_e'(req_type_i))
      REQ_GAIN: begin
        op   = OP_GAIN;
        keep = row_tab_ok && (32'(col_index_i) < 32'(MAX_DIMS));
      end
      REQ_PROJ: begin
        op   = OP_PROJ;
        keep = row_tab_ok && (32'(col_index_i) < 32'(MAX_POINTS));
      end
      REQ_BIAS: begin
        op   = OP_BIAS;
        keep = row_tab_ok;
      end
      REQ_FEAT: begin
        op   = feat_ok ? OP_FEAT : OP_RUN;
        keep = feat_ok || last_feature_i;
      end
      default: begin
        op   = OP_RUN;
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready_o = ~q_full_i;
  assign push_o     = in_valid_i && ~q_full_i && keep;
  assign cmd_o      = '{op: op, row: row_index_i, col: col_index_i, value: value_i,
                        last: last_feature_i};

endmodule

// ----- hdl/pplsr_queue.sv -----
// Short command queue between front end and back end.
// Depends on pplsr_pkg.
module pplsr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pplsr_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pplsr_pkg::cmd_t head_o
);
  import pplsr_pkg::*;

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

endmodule

// ----- hdl/pplsr_back.sv -----
// Back end: executes queued commands on the tables, accumulates responses,
// runs the projection sequencer and holds the output register. Uses pplsr_ram, pplsr_pkg.
module pplsr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pplsr_pkg::cfg_t                    cfg_i,
  input  logic                               q_valid_i,
  input  pplsr_pkg::cmd_t                    q_head_i,
  output logic                               q_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pplsr_pkg::SHAPE_W-1:0] shape_value_o,
  output logic [pplsr_pkg::ROW_W-1:0]        out_row_o,
  output logic                               last_o
);
  import pplsr_pkg::*;

  state_e state_q, state_d;

  logic [ROW_W-1:0]          feat_row_q;
  logic signed [VAL_W-1:0]   feat_val_q;
  logic                      feat_last_q;
  logic [PT_W-1:0]           i_q, j_q;
  logic                      s1_q, s2_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      rvld_q;
  logic [MAX_POINTS-1:0]     resp_vld_q;
  logic                      out_valid_q;
  logic signed [SHAPE_W-1:0] out_shape_q;
  logic [ROW_W-1:0]          out_row_q;
  logic                      out_last_q;

  logic q_pop;
  logic gain_we, gain_re, proj_we, proj_re, bias_we, bias_re, resp_we, resp_re;
  logic out_load;
  logic emit_last;
  logic dot_last;
  logic [PT_W-1:0] np_last;

  logic [GAIN_AW-1:0] gain_addr;
  logic [PROJ_AW-1:0] proj_waddr, proj_raddr;
  logic [PT_W-1:0]    resp_raddr;
  logic [VAL_W-1:0]   gain_rdata, proj_rdata, bias_rdata;
  logic [SHAPE_W-1:0] resp_rdata;

  logic signed [VAL_W-1:0]   mul_a;
  logic signed [SHAPE_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [SHAPE_W-1:0] resp_val;
  logic signed [VAL_W-1:0]   bias_s;
  logic signed [PROD_W-1:0]  feat_rnd;
  logic signed [SUM_W-1:0]   feat_sum;
  logic signed [SHAPE_W-1:0] resp_wdata;
  logic signed [SUM_W-1:0]   emit_total;
  logic signed [SUM_W-1:0]   emit_shift;

  assign np_last   = PT_W'(cfg_i.num_points - 1'b1);
  assign dot_last  = j_q == np_last;
  assign emit_last = i_q == np_last;

  assign gain_addr  = GAIN_AW'(q_head_i.row) * GAIN_AW'(MAX_DIMS) + GAIN_AW'(q_head_i.col);
  assign proj_waddr = PROJ_AW'(q_head_i.row) * PROJ_AW'(MAX_POINTS) + PROJ_AW'(q_head_i.col);
  assign proj_raddr = PROJ_AW'(i_q) * PROJ_AW'(MAX_POINTS) + PROJ_AW'(j_q);
  assign resp_raddr = (state_q == ST_DOT) ? j_q : PT_W'(q_head_i.row);

  pplsr_ram #(.Width(VAL_W), .Depth(GAIN_DEPTH)) u_gain_ram (
    .clk_i  (clk_i),
    .we_i   (gain_we),
    .waddr_i(gain_addr),
    .wdata_i(q_head_i.value),
    .re_i   (gain_re),
    .raddr_i(gain_addr),
    .rdata_o(gain_rdata)
  );

  pplsr_ram #(.Width(VAL_W), .Depth(PROJ_DEPTH)) u_proj_ram (
    .clk_i  (clk_i),
    .we_i   (proj_we),
    .waddr_i(proj_waddr),
    .wdata_i(q_head_i.value),
    .re_i   (proj_re),
    .raddr_i(proj_raddr),
    .rdata_o(proj_rdata)
  );

  pplsr_ram #(.Width(VAL_W), .Depth(MAX_POINTS)) u_bias_ram (
    .clk_i  (clk_i),
    .we_i   (bias_we),
    .waddr_i(PT_W'(q_head_i.row)),
    .wdata_i(q_head_i.value),
    .re_i   (bias_re),
    .raddr_i(i_q),
    .rdata_o(bias_rdata)
  );

  pplsr_ram #(.Width(SHAPE_W), .Depth(MAX_POINTS)) u_resp_ram (
    .clk_i  (clk_i),
    .we_i   (resp_we),
    .waddr_i(PT_W'(feat_row_q)),
    .wdata_i(resp_wdata),
    .re_i   (resp_re),
    .raddr_i(resp_raddr),
    .rdata_o(resp_rdata)
  );

  assign resp_val = rvld_q ? $signed(resp_rdata) : '0;
  assign bias_s   = $signed(bias_rdata);

  assign mul_a = (state_q == ST_FEAT_MUL) ? $signed(gain_rdata) : $signed(proj_rdata);
  assign mul_b = (state_q == ST_FEAT_MUL) ? SHAPE_W'(feat_val_q) : resp_val;
  assign mul_p = mul_a * mul_b;

  assign feat_rnd   = (prod_q + PROD_W'(ROUND_HALF)) >>> FRAC_BITS;
  assign feat_sum   = SUM_W'(resp_val) + SUM_W'(feat_rnd);
  assign resp_wdata = sat_shape(feat_sum);

  assign emit_total = SUM_W'(acc_q) + (SUM_W'(bias_s) <<< FRAC_BITS) + SUM_W'(ROUND_HALF);
  assign emit_shift = emit_total >>> FRAC_BITS;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.op == OP_FEAT) begin
            state_d = ST_FEAT_MUL;
          end else if (q_head_i.op == OP_RUN) begin
            state_d = ST_ROW;
          end
        end
      end
      ST_FEAT_MUL: state_d = ST_FEAT_ACC;
      ST_FEAT_ACC: state_d = feat_last_q ? ST_ROW : ST_IDLE;
      ST_ROW:      state_d = ST_DOT;
      ST_DOT:      state_d = dot_last ? ST_DRAIN : ST_DOT;
      ST_DRAIN:    state_d = (!s1_q && !s2_q) ? ST_EMIT : ST_DRAIN;
      ST_EMIT: begin
        if (out_load) begin
          state_d = emit_last ? ST_IDLE : ST_ROW;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    gain_we  = 1'b0;
    gain_re  = 1'b0;
    proj_we  = 1'b0;
    proj_re  = 1'b0;
    bias_we  = 1'b0;
    bias_re  = 1'b0;
    resp_we  = 1'b0;
    resp_re  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop = 1'b1;
          case (q_head_i.op)
            OP_GAIN: gain_we = 1'b1;
            OP_PROJ: proj_we = 1'b1;
            OP_BIAS: bias_we = 1'b1;
            OP_FEAT: begin
              gain_re = 1'b1;
              resp_re = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_FEAT_ACC: resp_we = 1'b1;
      ST_ROW:      bias_re = 1'b1;
      ST_DOT: begin
        proj_re = 1'b1;
        resp_re = 1'b1;
      end
      ST_EMIT:     out_load = ~out_valid_q | out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      resp_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_q    <= state_q == ST_DOT;
      s2_q    <= s1_q;
      if (state_q == ST_ROW) begin
        j_q <= '0;
      end else if (state_q == ST_DOT) begin
        j_q <= j_q + 1'b1;
      end
      if (resp_we) begin
        resp_vld_q[PT_W'(feat_row_q)] <= 1'b1;
      end
      if (out_load) begin
        i_q <= emit_last ? '0 : i_q + 1'b1;
        if (emit_last) begin
          resp_vld_q <= '0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      feat_row_q  <= q_head_i.row;
      feat_val_q  <= q_head_i.value;
      feat_last_q <= q_head_i.last;
    end
    if (resp_re) begin
      rvld_q <= resp_vld_q[resp_raddr];
    end
    if (state_q == ST_FEAT_MUL || s1_q) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_ROW) begin
      acc_q <= '0;
    end else if (s2_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (out_load) begin
      out_shape_q <= sat_shape(emit_shift);
      out_row_q   <= ROW_W'(i_q);
      out_last_q  <= emit_last;
    end
  end

  assign q_pop_o       = q_pop;
  assign out_valid_o   = out_valid_q;
  assign shape_value_o = out_shape_q;
  assign out_row_o     = out_row_q;
  assign last_o        = out_last_q;

  a_emit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> !s1_q && !s2_q)
    else $error("emit with dot pipeline still in flight");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid_i)
    else $error("pop from empty queue");

  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && emit_last) |=> (state_q == ST_IDLE) && (resp_vld_q == '0))
    else $error("responses not cleared after final result");

  a_resp_write_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_we |-> !s1_q && !s2_q && (state_q == ST_FEAT_ACC))
    else $error("response write overlaps projection pipeline");

endmodule

// ----- hdl/per_point_linear_shape_regressor.sv -----
// Top level of the per-point linear shape regressor: configuration registers,
// front end, command queue and back end. Uses pplsr_pkg, pplsr_front, pplsr_queue, pplsr_back.
//
//   port group   direction  handshake               payload
//   cfg          in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//   in           in         in_valid_i/in_ready_o   req_type_i, row_index_i, col_index_i,
//                                                   value_i, last_feature_i
//   out          out        out_valid_o/out_ready_i shape_value_o, out_row_o, last_o
//
// Table writes are done from the back end's idle state; an in-range feature goes through gain RAM read,
// multiply and accumulate on the single shared 16x32 multiplier.
// A run on the last feature takes, per row, a bias read, one projection MAC per cycle over
// num_points columns, pipeline drain and emit.
// A 4-entry command queue keeps accepting input while the back end works or the
// output stalls; in_ready_o drops only when the queue is full. No clearing pass after reset.
module per_point_linear_shape_regressor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pplsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [pplsr_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [pplsr_pkg::TYPE_W-1:0]         req_type_i,
  input  logic [pplsr_pkg::ROW_W-1:0]          row_index_i,
  input  logic [pplsr_pkg::COL_W-1:0]          col_index_i,
  input  logic signed [pplsr_pkg::VAL_W-1:0]   value_i,
  input  logic                                 last_feature_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [pplsr_pkg::SHAPE_W-1:0] shape_value_o,
  output logic [pplsr_pkg::ROW_W-1:0]          out_row_o,
  output logic                                 last_o
);
  import pplsr_pkg::*;

  cfg_t            cfg_q, cfg_d;
  logic [NP_W-1:0] np_raw;
  logic [ND_W-1:0] nd_raw;
  logic            q_full, q_push, q_pop, q_valid;
  cmd_t            push_cmd, head_cmd;

  assign np_raw = cfg_wdata_i[NP_W-1:0];
  assign nd_raw = cfg_wdata_i[ND_W-1:0];

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NUM_POINTS: begin
          if (np_raw == '0) begin
            cfg_d.num_points = NP_W'(1);
          end else if (32'(np_raw) > 32'(MAX_POINTS)) begin
            cfg_d.num_points = NP_W'(MAX_POINTS);
          end else begin
            cfg_d.num_points = np_raw;
          end
        end
        CFG_DIMS: begin
          if (nd_raw == '0) begin
            cfg_d.dims_per_point = ND_W'(1);
          end else if (32'(nd_raw) > 32'(MAX_DIMS)) begin
            cfg_d.dims_per_point = ND_W'(MAX_DIMS);
          end else begin
            cfg_d.dims_per_point = nd_raw;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_points     <= NP_W'(NP_RESET);
      cfg_q.dims_per_point <= ND_W'(ND_RESET);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pplsr_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .row_index_i   (row_index_i),
    .col_index_i   (col_index_i),
    .value_i       (value_i),
    .last_feature_i(last_feature_i),
    .cfg_i         (cfg_q),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .cmd_o         (push_cmd)
  );

  pplsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .head_o (head_cmd)
  );

  pplsr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_head_i     (head_cmd),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .shape_value_o(shape_value_o),
    .out_row_o    (out_row_o),
    .last_o       (last_o)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of per_point_linear_shape_regressor: loads the gain,
// projection and bias tables, streams feature transactions and checks every shape
// result against an in-line fixed-point predictor. Depends on pplsr_pkg and the block.
module tb_top;
  import pplsr_pkg::*;

  localparam int LIMIT      = 20000000;
  localparam int DRAIN      = 100;
  localparam int RAND_ITEMS = 500;
  localparam int IDLE_PCT   = 27;
  localparam int MAX_REPORT = 100;

  typedef struct {
    req_e                    kind;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    fin;
  } req_item_t;

  typedef struct {
    logic signed [SHAPE_W-1:0] shape;
    logic [ROW_W-1:0]          row;
    logic                      last;
  } shape_item_t;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i      = '0;
  logic [CFG_W-1:0]          cfg_wdata_i    = '0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic [TYPE_W-1:0]         req_type_i     = '0;
  logic [ROW_W-1:0]          row_index_i    = '0;
  logic [COL_W-1:0]          col_index_i    = '0;
  logic signed [VAL_W-1:0]   value_i        = '0;
  logic                      last_feature_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic signed [SHAPE_W-1:0] shape_value_o;
  logic [ROW_W-1:0]          out_row_o;
  logic                      last_o;

  logic signed [VAL_W-1:0]   gain_mem [GAIN_DEPTH];
  logic signed [VAL_W-1:0]   proj_mem [PROJ_DEPTH];
  logic signed [VAL_W-1:0]   bias_mem [MAX_POINTS];
  logic signed [SHAPE_W-1:0] resp_acc [MAX_POINTS];
  bit                        gain_ok  [GAIN_DEPTH];
  bit                        proj_ok  [PROJ_DEPTH];
  bit                        bias_ok  [MAX_POINTS];
  int                        np_cfg;
  int                        nd_cfg;

  req_item_t   req_q[$];
  shape_item_t shape_q[$];
  req_item_t   cur_req;
  shape_item_t want;
  logic        in_fire   = 1'b0;
  bit          calm      = 1'b0;
  int          item_cnt  = 0;
  int          err_cnt   = 0;
  int          cycle_cnt = 0;

  per_point_linear_shape_regressor i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint round_q12(longint x);
    return (x + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [SHAPE_W-1:0] sat32(longint x);
    if (x > ((64'sd1 <<< (SHAPE_W - 1)) - 1)) begin
      return {1'b0, {(SHAPE_W-1){1'b1}}};
    end else if (x < -(64'sd1 <<< (SHAPE_W - 1))) begin
      return {1'b1, {(SHAPE_W-1){1'b0}}};
    end
    return x[SHAPE_W-1:0];
  endfunction

  function automatic int clamp_cfg(int v, int hi);
    if (v < 1) begin
      return 1;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  function automatic int rand_word();
    case ($urandom_range(3))
      0: return -32768;
      1: return 32767;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < MAX_REPORT) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    err_cnt++;
  endtask

  task automatic apply_request(req_item_t it);
    longint      acc;
    shape_item_t s;
    int          r;
    int          c;
    r = it.row;
    c = it.col;
    case (it.kind)
      REQ_GAIN: gain_mem[r * MAX_DIMS + c] = it.value;
      REQ_PROJ: begin
        if (c < MAX_POINTS) begin
          proj_mem[r * MAX_POINTS + c] = it.value;
        end
      end
      REQ_BIAS: bias_mem[r] = it.value;
      default: begin
        if (r < np_cfg && c < nd_cfg) begin
          resp_acc[r] = sat32(longint'(resp_acc[r]) +
                              round_q12(longint'(gain_mem[r * MAX_DIMS + c]) *
                                        longint'(it.value)));
        end
        if (it.fin) begin
          for (int i = 0; i < np_cfg; i++) begin
            acc = longint'(bias_mem[i]) <<< FRAC_BITS;
            for (int j = 0; j < np_cfg; j++) begin
              acc += longint'(proj_mem[i * MAX_POINTS + j]) * longint'(resp_acc[j]);
            end
            s.shape = sat32(round_q12(acc));
            s.row   = ROW_W'(i);
            s.last  = (i == np_cfg - 1);
            shape_q.push_back(s);
          end
          for (int i = 0; i < MAX_POINTS; i++) begin
            resp_acc[i] = '0;
          end
        end
      end
    endcase
  endtask

  task automatic push_item(req_e kind, int row, int col, int value, bit fin);
    req_item_t it;
    bit        hit;
    hit = (row < np_cfg) && (col < nd_cfg);
    if (kind == REQ_FEAT && hit && !gain_ok[row * MAX_DIMS + col]) begin
      push_item(REQ_GAIN, row, col, rand_word(), 1'b0);
    end
    it.kind  = kind;
    it.row   = ROW_W'(row);
    it.col   = COL_W'(col);
    it.value = VAL_W'(value);
    it.fin   = fin;
    req_q.push_back(it);
    case (kind)
      REQ_GAIN: begin
        gain_ok[row * MAX_DIMS + col] = 1'b1;
        item_cnt++;
      end
      REQ_PROJ: begin
        if (col < MAX_POINTS) begin
          proj_ok[row * MAX_POINTS + col] = 1'b1;
          item_cnt++;
        end
      end
      REQ_BIAS: begin
        bias_ok[row] = 1'b1;
        item_cnt++;
      end
      default: begin
        if (hit || fin) begin
          item_cnt++;
        end
      end
    endcase
  endtask

  task automatic prep_tables();
    for (int i = 0; i < np_cfg; i++) begin
      if (!bias_ok[i]) begin
        push_item(REQ_BIAS, i, $urandom_range(MAX_DIMS - 1), rand_word(), 1'b0);
      end
      for (int j = 0; j < np_cfg; j++) begin
        if (!proj_ok[i * MAX_POINTS + j]) begin
          push_item(REQ_PROJ, i, j, rand_word(), $urandom_range(1));
        end
      end
    end
  endtask

  task automatic pick_feat(output int row, output int col, input bit miss);
    row = $urandom_range(np_cfg - 1);
    col = $urandom_range(nd_cfg - 1);
    if (miss) begin
      if (np_cfg < MAX_POINTS && ($urandom_range(1) == 0 || nd_cfg == MAX_DIMS)) begin
        row = $urandom_range(MAX_POINTS - 1, np_cfg);
      end else if (nd_cfg < MAX_DIMS) begin
        col = $urandom_range(MAX_DIMS - 1, nd_cfg);
      end
    end
  endtask

  task automatic push_random_run();
    int row;
    int col;
    repeat ($urandom_range(3)) begin
      push_item(req_e'($urandom_range(2)), $urandom_range(MAX_POINTS - 1),
                $urandom_range(MAX_DIMS - 1), rand_word(), $urandom_range(1));
    end
    repeat ($urandom_range(12, 1)) begin
      pick_feat(row, col, $urandom_range(7) == 0);
      push_item(REQ_FEAT, row, col, rand_word(), 1'b0);
    end
    pick_feat(row, col, $urandom_range(5) == 0);
    push_item(REQ_FEAT, row, col, rand_word(), 1'b1);
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        push_item(req_e'($urandom_range(3)), $urandom_range(MAX_POINTS - 1),
                  $urandom_range(MAX_DIMS - 1), rand_word(), $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic cfg_write(cfg_idx_e idx, int data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_POINTS) begin
      np_cfg = clamp_cfg(data & ((1 << NP_W) - 1), MAX_POINTS);
    end else begin
      nd_cfg = clamp_cfg(data & ((1 << ND_W) - 1), MAX_DIMS);
    end
  endtask

  task automatic settle();
    while (req_q.size() != 0 || in_valid_i || shape_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (in_valid_i && in_fire) begin
        apply_request(cur_req);
      end
      if (!in_valid_i || in_fire) begin
        if (req_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur_req        = req_q.pop_front();
          req_type_i     <= cur_req.kind;
          row_index_i    <= cur_req.row;
          col_index_i    <= cur_req.col;
          value_i        <= cur_req.value;
          last_feature_i <= cur_req.fin;
          in_valid_i     <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        if (shape_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, row %0d shape_value %0d",
                                    out_row_o, shape_value_o));
        end else begin
          want = shape_q.pop_front();
          if (shape_value_o !== want.shape) begin
            report_mismatch($sformatf("row %0d: shape_value %0d, expected %0d",
                                      want.row, shape_value_o, want.shape));
          end
          if (out_row_o !== want.row) begin
            report_mismatch($sformatf("out_row %0d, expected %0d", out_row_o, want.row));
          end
          if (last_o !== want.last) begin
            report_mismatch($sformatf("row %0d: last %0b, expected %0b",
                                      want.row, last_o, want.last));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int base;
    int mark;
    for (int i = 0; i < MAX_POINTS; i++) begin
      resp_acc[i] = '0;
    end
    np_cfg = NP_RESET;
    nd_cfg = ND_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Register values below range clamp to one point and one dimension.
    cfg_write(CFG_NUM_POINTS, 0);
    cfg_write(CFG_DIMS, 0);
    prep_tables();
    push_item(REQ_GAIN, 63, 127, -32768, 1'b1);
    push_item(REQ_GAIN, 0, 0, 32767, 1'b0);
    push_item(REQ_PROJ, 63, 127, rand_word(), 1'b0);
    push_item(REQ_PROJ, 0, 64, rand_word(), 1'b1);
    push_item(REQ_PROJ, 0, 0, -32768, 1'b0);
    push_item(REQ_BIAS, 0, 127, 32767, 1'b1);
    push_item(REQ_FEAT, 0, 0, -32768, 1'b0);
    push_item(REQ_FEAT, 63, 0, 32767, 1'b0);
    push_item(REQ_FEAT, 0, 127, 1, 1'b0);
    push_item(REQ_FEAT, 0, 0, 32767, 1'b1);
    push_item(REQ_FEAT, 5, 3, rand_word(), 1'b1);
    push_item(REQ_BIAS, 0, 0, -32768, 1'b0);
    push_item(REQ_GAIN, 0, 0, -1, 1'b0);
    push_item(REQ_FEAT, 0, 0, 1, 1'b0);
    push_item(REQ_FEAT, 0, 0, 2048, 1'b0);
    push_item(REQ_FEAT, 0, 0, -2048, 1'b0);
    push_item(REQ_FEAT, 0, 0, -1, 1'b1);
    settle();

    // No idling: point count keeps its low seven bits, dimension count clamps high.
    calm = 1'b1;
    cfg_write(CFG_NUM_POINTS, 'h84);
    cfg_write(CFG_DIMS, 'hff);
    prep_tables();
    for (int j = 0; j < np_cfg; j++) begin
      push_item(REQ_PROJ, 0, j, 32767, 1'b0);
      push_item(REQ_PROJ, 1, j, -32768, 1'b0);
    end
    for (int p = 0; p < np_cfg; p++) begin
      for (int d = MAX_DIMS - 8; d < MAX_DIMS; d++) begin
        push_item(REQ_GAIN, p, d, -32768, 1'b0);
        push_item(REQ_FEAT, p, d, -32768, 1'b0);
      end
    end
    push_item(REQ_FEAT, np_cfg - 1, MAX_DIMS - 1, rand_word(), 1'b1);
    settle();

    calm = 1'b0;
    base = item_cnt;
    while (item_cnt - base < RAND_ITEMS) begin
      calm = ($urandom_range(3) == 0);
      cfg_write(CFG_NUM_POINTS,
                ($urandom_range(4) == 0) ? 128 + $urandom_range(8) : $urandom_range(8, 1));
      cfg_write(CFG_DIMS,
                ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(16, 1));
      prep_tables();
      mark = item_cnt;
      while (item_cnt - mark < 60) begin
        push_random_run();
      end
      settle();
    end

    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
